// File: rtl/kgc_pkg.sv
// package for the knock gain calibration tap: widths, codes, queue entry type
// and back-end state encoding; no dependencies
package kgc_pkg;

  localparam int NUM_CYL_DEF = 4;   // default cylinder count
  localparam int MEAN_INPUTS = 4;   // mean noise inputs on the event
  localparam int MEAN_IDX_W  = 2;
  localparam int CYL_W       = 3;
  localparam int DATA_W      = 16;
  localparam int GAIN_W      = 8;
  localparam int SNR_SHIFT   = 5;   // noise difference times 32
  localparam int SAT_SHIFT   = 6;   // tap feed times 64
  localparam int NUM_W       = DATA_W + SNR_SHIFT;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BENCH_ENABLE = 1'd0,
    REG_CHANNEL_MODE = 1'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_INST  = 2'd0,
    MODE_MEAN  = 2'd1,
    MODE_GAIN  = 2'd2,
    MODE_KNOCK = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_COMMIT
  } back_state_t;

  // one classified event waiting for the back end
  typedef struct packed {
    logic              cyl_ok;
    logic [CYL_W-1:0]  cyl;
    logic [DATA_W-1:0] inst;
    logic [DATA_W-1:0] mean;     // previous mean noise of the event cylinder
    logic              diff_pos; // inst_noise above noise_offset
    logic [NUM_W-1:0]  num;      // difference times 32, meaningful only when diff_pos
    logic              knock;
  } kgc_cmd_t;

  // divider handshake
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DATA_W-1:0] den;
  } kgc_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } kgc_div_rsp_t;

endpackage

// File: rtl/kgc_front.sv
// front end: accepts events, classifies the cylinder, looks up the previous
// mean noise and forms the division numerator; uses kgc_pkg
module kgc_front #(
  parameter int NUM_CYL = kgc_pkg::NUM_CYL_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [kgc_pkg::CYL_W-1:0]  cylinder,
  input  logic [kgc_pkg::DATA_W-1:0] inst_noise,
  input  logic [kgc_pkg::DATA_W-1:0] noise_offset,
  input  logic                       knock_flag,
  input  logic [kgc_pkg::DATA_W-1:0] mean_noise_cyl0,
  input  logic [kgc_pkg::DATA_W-1:0] mean_noise_cyl1,
  input  logic [kgc_pkg::DATA_W-1:0] mean_noise_cyl2,
  input  logic [kgc_pkg::DATA_W-1:0] mean_noise_cyl3,
  input  logic                       queue_full,
  output logic                       push,
  output kgc_pkg::kgc_cmd_t          cmd
);
  import kgc_pkg::*;

  logic [DATA_W-1:0] prev_mean [MEAN_INPUTS];
  logic [DATA_W:0]   diff;
  logic              has_mean;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  assign diff     = {1'b0, inst_noise} - {1'b0, noise_offset};
  assign has_mean = ({1'b0, cylinder} < (CYL_W + 1)'(MEAN_INPUTS));

  always_comb begin
    cmd.cyl_ok   = ({1'b0, cylinder} < (CYL_W + 1)'(NUM_CYL));
    cmd.cyl      = cylinder;
    cmd.inst     = inst_noise;
    cmd.mean     = has_mean ? prev_mean[cylinder[MEAN_IDX_W-1:0]] : '0;
    cmd.diff_pos = !diff[DATA_W] && (diff[DATA_W-1:0] != '0);
    cmd.num      = {diff[DATA_W-1:0], {SNR_SHIFT{1'b0}}};
    cmd.knock    = knock_flag;
  end

  // previous means follow every accepted event, enabled or not
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MEAN_INPUTS; i++) prev_mean[i] <= '0;
    end else if (push) begin
      prev_mean[0] <= mean_noise_cyl0;
      prev_mean[1] <= mean_noise_cyl1;
      prev_mean[2] <= mean_noise_cyl2;
      prev_mean[3] <= mean_noise_cyl3;
    end
  end

endmodule

// File: rtl/kgc_queue.sv
// short queue of classified events between front and back end
// depends on kgc_pkg
module kgc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kgc_pkg::kgc_cmd_t push_data,
  input  logic              pop,
  output kgc_pkg::kgc_cmd_t head,
  output logic              full,
  output logic              not_empty
);
  import kgc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  kgc_cmd_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: rtl/kgc_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on kgc_pkg
module kgc_div (
  input  logic                  clk,
  input  logic                  rst,
  input  kgc_pkg::kgc_div_req_t req,
  output kgc_pkg::kgc_div_rsp_t rsp
);
  import kgc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [NUM_W-1:0]  quo;     // dividend bits shift out, quotient bits shift in
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] den;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W+1:0] trial;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den};

  assign rsp.done = done;
  assign rsp.quot = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      if (!trial[DATA_W+1]) begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/kgc_back.sv
// back end: runs the gain division, updates gain table, delay line and
// holds, and presents the result; uses kgc_pkg
module kgc_back #(
  parameter int NUM_CYL = kgc_pkg::NUM_CYL_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       bench_enable,
  input  kgc_pkg::mode_t             channel_mode,
  input  logic                       cmd_avail,
  input  kgc_pkg::kgc_cmd_t          cmd,
  output logic                       pop,
  output kgc_pkg::kgc_div_req_t      div_req,
  input  kgc_pkg::kgc_div_rsp_t      div_rsp,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [kgc_pkg::DATA_W-1:0] tap_0,
  output logic [kgc_pkg::DATA_W-1:0] tap_1,
  output logic [kgc_pkg::DATA_W-1:0] tap_2,
  output logic [kgc_pkg::DATA_W-1:0] tap_3,
  output logic [kgc_pkg::GAIN_W-1:0] gain_out,
  output logic [kgc_pkg::DATA_W-1:0] held_inst_noise,
  output logic [kgc_pkg::DATA_W-1:0] held_mean_noise,
  output logic                       held_knock,
  output logic                       cyl_error
);
  import kgc_pkg::*;

  localparam int GIDX_W = (NUM_CYL > 1) ? $clog2(NUM_CYL) : 1;

  back_state_t       state, state_next;
  kgc_cmd_t          cur;
  logic [GAIN_W-1:0] gain_new;
  logic [GAIN_W-1:0] gain_table [NUM_CYL];
  logic [DATA_W-1:0] taps [4];
  logic [DATA_W-1:0] inst_hold;
  logic [DATA_W-1:0] mean_hold;
  logic              knock_hold;
  logic [GIDX_W-1:0] gidx;
  logic [DATA_W-1:0] tap_new;
  logic [GAIN_W-1:0] gain_clamp;
  logic              commit;
  logic              apply;

  assign gidx  = cur.cyl[GIDX_W-1:0];
  assign apply = bench_enable && cur.cyl_ok;

  assign gain_clamp = (|div_rsp.quot[NUM_W-1:GAIN_W]) ? {GAIN_W{1'b1}}
                                                       : div_rsp.quot[GAIN_W-1:0];

  always_comb begin
    state_next    = state;
    pop           = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = cmd.num;
    div_req.den   = cmd.mean;
    commit        = 1'b0;
    case (state)
      BK_IDLE: begin
        if (cmd_avail) begin
          pop = 1'b1;
          if (bench_enable && cmd.cyl_ok && cmd.mean != '0 && cmd.diff_pos) begin
            div_req.start = 1'b1;
            state_next    = BK_DIV;
          end else begin
            state_next = BK_COMMIT;
          end
        end
      end
      BK_DIV: begin
        if (div_rsp.done) state_next = BK_COMMIT;
      end
      BK_COMMIT: begin
        if (!out_valid || !out_stall) begin
          commit     = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // feed for the newest tap
  always_comb begin
    case (channel_mode)
      MODE_INST: begin
        tap_new = (|cur.inst[DATA_W-1:DATA_W-SAT_SHIFT]) ? {DATA_W{1'b1}}
                : {cur.inst[DATA_W-SAT_SHIFT-1:0], {SAT_SHIFT{1'b0}}};
      end
      MODE_MEAN: begin
        tap_new = (|cur.mean[DATA_W-1:DATA_W-SAT_SHIFT]) ? {DATA_W{1'b1}}
                : {cur.mean[DATA_W-SAT_SHIFT-1:0], {SAT_SHIFT{1'b0}}};
      end
      MODE_GAIN:  tap_new = {gain_new, {(DATA_W - GAIN_W){1'b0}}};
      MODE_KNOCK: tap_new = {DATA_W{cur.knock}};
      default:    tap_new = {DATA_W{cur.knock}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= cmd;
      gain_new <= (cmd.mean == '0) ? {GAIN_W{1'b1}} : '0;
    end else if (div_rsp.done) begin
      gain_new <= gain_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CYL; i++) gain_table[i] <= '0;
      for (int i = 0; i < 4; i++) taps[i] <= '0;
      inst_hold  <= '0;
      mean_hold  <= '0;
      knock_hold <= 1'b0;
      gain_out   <= '0;
      cyl_error  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
        cyl_error <= !cur.cyl_ok;
        if (!cur.cyl_ok) gain_out <= '0;
        else if (bench_enable) gain_out <= gain_new;
        else gain_out <= gain_table[gidx];
        if (bench_enable) begin
          taps[1] <= taps[0];
          taps[2] <= taps[1];
          taps[3] <= taps[2];
        end
        if (apply) begin
          gain_table[gidx] <= gain_new;
          taps[0]          <= tap_new;
          inst_hold        <= cur.inst;
          mean_hold        <= cur.mean;
          knock_hold       <= cur.knock;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign tap_0           = taps[0];
  assign tap_1           = taps[1];
  assign tap_2           = taps[2];
  assign tap_3           = taps[3];
  assign held_inst_noise = inst_hold;
  assign held_mean_noise = mean_hold;
  assign held_knock      = knock_hold;

  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == BK_DIV)
    else $error("divider finished outside the divide state");

  a_commit_waits: assert property (@(posedge clk) disable iff (rst)
    state == BK_COMMIT && out_valid && out_stall |=> state == BK_COMMIT)
    else $error("result committed over a stalled result");

  a_error_zero_gain: assert property (@(posedge clk) disable iff (rst)
    out_valid && cyl_error |-> gain_out == '0)
    else $error("gain reported for an invalid cylinder");

  a_start_on_pop: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> pop && state == BK_IDLE)
    else $error("divider started without taking a queue entry");

endmodule

// File: rtl/knock_gain_calibration_tap_top.sv
// with a division an event goes through the queue, the divider start, the restoring
// divider and the commit state; otherwise it goes from the queue straight to commit
// while dividing, the back end takes no new event until the result is committed;
// a two-entry queue lets the front take events while the back end divides
// reset: synchronous, clears config, previous means, gain table, delay line,
// holds, the queue and the divider control; no clearing pass
module knock_gain_calibration_tap_top #(
  parameter int NUM_CYL = kgc_pkg::NUM_CYL_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [kgc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kgc_pkg::CFG_DATA_W-1:0] cfg_data,
  // event input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kgc_pkg::CYL_W-1:0]      cylinder,
  input  logic [kgc_pkg::DATA_W-1:0]     inst_noise,
  input  logic [kgc_pkg::DATA_W-1:0]     noise_offset,
  input  logic                           knock_flag,
  input  logic [kgc_pkg::DATA_W-1:0]     mean_noise_cyl0,
  input  logic [kgc_pkg::DATA_W-1:0]     mean_noise_cyl1,
  input  logic [kgc_pkg::DATA_W-1:0]     mean_noise_cyl2,
  input  logic [kgc_pkg::DATA_W-1:0]     mean_noise_cyl3,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kgc_pkg::DATA_W-1:0]     tap_0,
  output logic [kgc_pkg::DATA_W-1:0]     tap_1,
  output logic [kgc_pkg::DATA_W-1:0]     tap_2,
  output logic [kgc_pkg::DATA_W-1:0]     tap_3,
  output logic [kgc_pkg::GAIN_W-1:0]     gain_out,
  output logic [kgc_pkg::DATA_W-1:0]     held_inst_noise,
  output logic [kgc_pkg::DATA_W-1:0]     held_mean_noise,
  output logic                           held_knock,
  output logic                           cyl_error
);
  import kgc_pkg::*;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  logic         bench_enable;
  mode_t        channel_mode;

  // front to queue
  logic         push;
  kgc_cmd_t     push_cmd;
  logic         queue_full;

  // queue to back end
  logic         pop;
  logic         cmd_avail;
  kgc_cmd_t     head_cmd;

  // back end to divider
  kgc_div_req_t div_req;
  kgc_div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      bench_enable <= 1'b0;
      channel_mode <= MODE_INST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BENCH_ENABLE: bench_enable <= cfg_data[0];
        REG_CHANNEL_MODE: channel_mode <= mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // front: classify the cylinder, look up previous mean, build numerator
  kgc_front #(
    .NUM_CYL(NUM_CYL)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cylinder       (cylinder),
    .inst_noise     (inst_noise),
    .noise_offset   (noise_offset),
    .knock_flag     (knock_flag),
    .mean_noise_cyl0(mean_noise_cyl0),
    .mean_noise_cyl1(mean_noise_cyl1),
    .mean_noise_cyl2(mean_noise_cyl2),
    .mean_noise_cyl3(mean_noise_cyl3),
    .queue_full     (queue_full),
    .push           (push),
    .cmd            (push_cmd)
  );

  // decoupling queue, lets the front take events while the back divides
  kgc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .full     (queue_full),
    .not_empty(cmd_avail)
  );

  // serial divider for the signal-to-noise gain
  kgc_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // back end: gain table, delay line, holds and result register
  kgc_back #(
    .NUM_CYL(NUM_CYL)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .bench_enable   (bench_enable),
    .channel_mode   (channel_mode),
    .cmd_avail      (cmd_avail),
    .cmd            (head_cmd),
    .pop            (pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .tap_0          (tap_0),
    .tap_1          (tap_1),
    .tap_2          (tap_2),
    .tap_3          (tap_3),
    .gain_out       (gain_out),
    .held_inst_noise(held_inst_noise),
    .held_mean_noise(held_mean_noise),
    .held_knock     (held_knock),
    .cyl_error      (cyl_error)
  );

endmodule

// File: tb/tb_knock_gain_calibration_tap_top.sv
// self-checking testbench for the knock gain calibration tap: directed and random
// knock window events against an in-bench gain and delay line predictor
// depends on kgc_pkg and knock_gain_calibration_tap_top
module tb_knock_gain_calibration_tap_top;
  import kgc_pkg::*;

  localparam int CYL_COUNT = NUM_CYL_DEF;

  // one knock window event as it appears on the input channel
  typedef struct packed {
    logic [CYL_W-1:0]              cyl;
    logic [DATA_W-1:0]             inst;
    logic [DATA_W-1:0]             offs;
    logic                          knock;
    logic [MEAN_INPUTS-1:0][DATA_W-1:0] mean;
  } knock_event_t;

  // one result transaction
  typedef struct packed {
    logic [DATA_W-1:0] t0;
    logic [DATA_W-1:0] t1;
    logic [DATA_W-1:0] t2;
    logic [DATA_W-1:0] t3;
    logic [GAIN_W-1:0] gain;
    logic [DATA_W-1:0] hinst;
    logic [DATA_W-1:0] hmean;
    logic              hknock;
    logic              err;
  } tap_result_t;

  // block inputs, all known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  reg_index_t            cfg_index = REG_BENCH_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic [CYL_W-1:0]      cylinder = '0;
  logic [DATA_W-1:0]     inst_noise = '0;
  logic [DATA_W-1:0]     noise_offset = '0;
  logic                  knock_flag = 1'b0;
  logic [DATA_W-1:0]     mean_noise_cyl0 = '0;
  logic [DATA_W-1:0]     mean_noise_cyl1 = '0;
  logic [DATA_W-1:0]     mean_noise_cyl2 = '0;
  logic [DATA_W-1:0]     mean_noise_cyl3 = '0;
  logic                  out_stall = 1'b0;

  // block outputs
  logic              in_stall;
  logic              out_valid;
  logic [DATA_W-1:0] tap_0;
  logic [DATA_W-1:0] tap_1;
  logic [DATA_W-1:0] tap_2;
  logic [DATA_W-1:0] tap_3;
  logic [GAIN_W-1:0] gain_out;
  logic [DATA_W-1:0] held_inst_noise;
  logic [DATA_W-1:0] held_mean_noise;
  logic              held_knock;
  logic              cyl_error;

  // predictor state: shadow config, previous means, gains, delay line, holds
  logic                          bench_on = 1'b0;
  mode_t                         feed_mode = MODE_INST;
  logic [DATA_W-1:0]             prev_mean [MEAN_INPUTS];
  logic [GAIN_W-1:0]             gain_tbl [MEAN_INPUTS];
  logic [DATA_W-1:0]             taps [4];
  logic [DATA_W-1:0]             inst_hold = '0;
  logic [DATA_W-1:0]             mean_hold = '0;
  logic                          knock_hold = 1'b0;

  tap_result_t expected_taps [$];  // predicted results, oldest first
  int          fail_count = 0;

  // receiver stall pattern controls
  int stall_pct = 0;
  int stall_run = 0;

  knock_gain_calibration_tap_top u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cylinder        (cylinder),
    .inst_noise      (inst_noise),
    .noise_offset    (noise_offset),
    .knock_flag      (knock_flag),
    .mean_noise_cyl0 (mean_noise_cyl0),
    .mean_noise_cyl1 (mean_noise_cyl1),
    .mean_noise_cyl2 (mean_noise_cyl2),
    .mean_noise_cyl3 (mean_noise_cyl3),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .tap_0           (tap_0),
    .tap_1           (tap_1),
    .tap_2           (tap_2),
    .tap_3           (tap_3),
    .gain_out        (gain_out),
    .held_inst_noise (held_inst_noise),
    .held_mean_noise (held_mean_noise),
    .held_knock      (held_knock),
    .cyl_error       (cyl_error)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < MEAN_INPUTS; i++) begin
      prev_mean[i] = '0;
      gain_tbl[i]  = '0;
      taps[i]      = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // signal-to-noise gain: signed difference times 32 over the previous mean,
  // truncated toward zero and clamped to the 8-bit range; zero mean gives full gain
  function automatic logic [GAIN_W-1:0] snr_gain(logic [DATA_W-1:0] inst,
                                                 logic [DATA_W-1:0] offs,
                                                 logic [DATA_W-1:0] mean);
    int diff;
    int q;
    if (mean == '0) return 8'd255;
    diff = int'(inst) - int'(offs);
    q = (diff * 32) / int'(mean);
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[GAIN_W-1:0];
  endfunction

  // value times 64, saturated to 16 bits
  function automatic logic [DATA_W-1:0] sat_x64(logic [DATA_W-1:0] v);
    logic [DATA_W+SAT_SHIFT-1:0] p;
    p = {v, {SAT_SHIFT{1'b0}}};
    return (p > 65535) ? 16'hFFFF : p[DATA_W-1:0];
  endfunction

  // advance the predictor by one accepted event and queue the result it gives
  task automatic predict_tap_result(input knock_event_t ev);
    logic        ok;
    logic [1:0]  c;
    tap_result_t r;
    ok = (ev.cyl < CYL_COUNT);
    c  = ev.cyl[1:0];
    if (bench_on) begin
      if (ok) gain_tbl[c] = snr_gain(ev.inst, ev.offs, prev_mean[c]);
      taps[3] = taps[2];
      taps[2] = taps[1];
      taps[1] = taps[0];
      // a bad cylinder shifts the line but leaves tap 0 and the holds alone
      if (ok) begin
        inst_hold  = ev.inst;
        mean_hold  = prev_mean[c];
        knock_hold = ev.knock;
        case (feed_mode)
          MODE_INST: taps[0] = sat_x64(inst_hold);
          MODE_MEAN: taps[0] = sat_x64(mean_hold);
          MODE_GAIN: taps[0] = {gain_tbl[c], 8'h00};
          default:   taps[0] = {DATA_W{knock_hold}};
        endcase
      end
    end
    // means are captured whether or not the bench is enabled
    for (int i = 0; i < MEAN_INPUTS; i++) prev_mean[i] = ev.mean[i];
    r.t0     = taps[0];
    r.t1     = taps[1];
    r.t2     = taps[2];
    r.t3     = taps[3];
    r.gain   = ok ? gain_tbl[c] : '0;
    r.hinst  = inst_hold;
    r.hmean  = mean_hold;
    r.hknock = knock_hold;
    r.err    = ~ok;
    expected_taps.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) note_failure($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  // sample each result transaction at the rising edge, against the oldest prediction
  always @(posedge clk) begin : result_check
    tap_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_taps.size() == 0) begin
        note_failure("result transaction with nothing expected");
      end else begin
        want = expected_taps.pop_front();
        check_field("tap_0", want.t0, tap_0);
        check_field("tap_1", want.t1, tap_1);
        check_field("tap_2", want.t2, tap_2);
        check_field("tap_3", want.t3, tap_3);
        check_field("gain_out", DATA_W'(want.gain), DATA_W'(gain_out));
        check_field("held_inst_noise", want.hinst, held_inst_noise);
        check_field("held_mean_noise", want.hmean, held_mean_noise);
        check_field("held_knock", DATA_W'(want.hknock), DATA_W'(held_knock));
        check_field("cyl_error", DATA_W'(want.err), DATA_W'(cyl_error));
      end
    end
  end

  // receiver stall pattern: random stall runs, each started with a chance of stall_pct in 100
  always @(negedge clk) begin
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_run = $urandom_range(7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // drive one event at the falling edge and hold it until the transaction
  task automatic send_event(input knock_event_t ev);
    @(negedge clk);
    in_valid        <= 1'b1;
    cylinder        <= ev.cyl;
    inst_noise      <= ev.inst;
    noise_offset    <= ev.offs;
    knock_flag      <= ev.knock;
    mean_noise_cyl0 <= ev.mean[0];
    mean_noise_cyl1 <= ev.mean[1];
    mean_noise_cyl2 <= ev.mean[2];
    mean_noise_cyl3 <= ev.mean[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tap_result(ev);
  endtask

  // drop valid for an idle gap set by n; n of zero keeps the burst going
  task automatic idle_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // stop sending and wait for every predicted result to come back
  task automatic wait_drained();
    idle_sender(1);
    while (expected_taps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, only with the block drained
  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_BENCH_ENABLE: bench_on  = val[0];
      REG_CHANNEL_MODE: feed_mode = mode_t'(val);
      default: ;
    endcase
  endtask

  function automatic knock_event_t make_event(int cyl, int inst, int offs, int knock,
                                              int m0, int m1, int m2, int m3);
    knock_event_t ev;
    ev.cyl     = cyl[CYL_W-1:0];
    ev.inst    = inst[DATA_W-1:0];
    ev.offs    = offs[DATA_W-1:0];
    ev.knock   = knock[0];
    ev.mean[0] = m0[DATA_W-1:0];
    ev.mean[1] = m1[DATA_W-1:0];
    ev.mean[2] = m2[DATA_W-1:0];
    ev.mean[3] = m3[DATA_W-1:0];
    return ev;
  endfunction

  // random event: mostly valid cylinders with the noise difference aimed at the
  // previous mean so gains spread over the whole range, plus raw noise and edges
  function automatic knock_event_t random_event();
    knock_event_t ev;
    int sel;
    int g;
    int span;
    sel = $urandom_range(99);
    ev.cyl   = CYL_W'(($urandom_range(99) < 88) ? $urandom_range(CYL_COUNT - 1)
                                                : $urandom_range(7, CYL_COUNT));
    ev.knock = 1'($urandom_range(1));
    for (int i = 0; i < MEAN_INPUTS; i++) begin
      case ($urandom_range(9))
        0:       ev.mean[i] = '0;
        1, 2:    ev.mean[i] = DATA_W'($urandom);
        3:       ev.mean[i] = DATA_W'($urandom_range(1100, 900));  // around x64 saturation
        default: ev.mean[i] = DATA_W'($urandom_range(4095, 1));
      endcase
    end
    if (sel < 70) begin
      ev.offs = DATA_W'($urandom_range(30000));
      g       = $urandom_range(300);
      span    = int'(prev_mean[ev.cyl[1:0]]) * g / 32 + $urandom_range(3);
      ev.inst = (int'(ev.offs) + span > 65535) ? 16'hFFFF : ev.offs + span[DATA_W-1:0];
    end else if (sel < 88) begin
      ev.inst = DATA_W'($urandom);
      ev.offs = DATA_W'($urandom);
    end else begin
      ev.inst = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
      ev.offs = ($urandom_range(2) == 0) ? 16'hFFFF
              : (($urandom_range(1)) ? 16'h0 : DATA_W'($urandom));
    end
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // straight after reset the bench is off: only the means are captured and
  // the result shows the cleared state, with the error flag on a bad cylinder
  task automatic test_disabled_after_reset();
    send_event(make_event(0, 1000, 0, 1, 100, 1, 0, 65535));
    send_event(make_event(5, 2000, 10, 1, 100, 1, 0, 65535));
  endtask

  // every feed mode with the gain corner cases: zero mean, negative
  // difference, exact and clamped gains, x64 saturation, bad cylinders
  task automatic test_feed_modes();
    write_reg(REG_BENCH_ENABLE, 2'd1);
    write_reg(REG_CHANNEL_MODE, MODE_INST);
    send_event(make_event(2, 65535, 0, 1, 100, 1, 0, 65535));     // zero mean, full gain
    send_event(make_event(0, 50, 40, 0, 100, 1, 0, 65535));       // small truncated gain
    send_event(make_event(1, 65535, 0, 1, 100, 1, 0, 65535));     // clamps high
    send_event(make_event(3, 65535, 0, 0, 32, 200, 0, 65535));    // full-scale mean
    send_event(make_event(4, 7, 7, 1, 32, 200, 0, 65535));        // bad cylinder
    send_event(make_event(7, 9, 9, 0, 32, 200, 0, 65535));        // top bad cylinder
    send_event(make_event(0, 300, 45, 1, 1023, 1024, 0, 65535));  // gain exactly 255
    send_event(make_event(1, 100, 300, 0, 1023, 1024, 0, 65535)); // negative difference
    write_reg(REG_CHANNEL_MODE, MODE_MEAN);
    send_event(make_event(0, 1, 1, 1, 100, 1024, 0, 65535));      // mean just below saturation
    send_event(make_event(1, 2, 2, 0, 100, 1024, 0, 65535));      // mean saturates
    send_event(make_event(3, 1, 0, 1, 100, 1024, 0, 0));          // full-scale mean
    send_event(make_event(2, 0, 65535, 0, 100, 1024, 0, 0));      // zero mean, negative diff
    write_reg(REG_CHANNEL_MODE, MODE_GAIN);
    send_event(make_event(0, 4000, 100, 1, 100, 1024, 0, 0));
    send_event(make_event(2, 0, 0, 0, 100, 1024, 0, 0));          // zero mean gain into tap
    send_event(make_event(6, 0, 0, 1, 100, 1024, 0, 0));
    write_reg(REG_CHANNEL_MODE, MODE_KNOCK);
    send_event(make_event(1, 500, 500, 1, 100, 1024, 0, 0));      // equal noise and offset
    send_event(make_event(0, 800, 0, 0, 100, 1024, 0, 0));
    send_event(make_event(5, 800, 0, 1, 100, 1024, 0, 0));
    // disabled again: stored gains and holds are reported unchanged
    write_reg(REG_BENCH_ENABLE, 2'd2);
    send_event(make_event(0, 123, 4, 1, 11, 22, 33, 44));
    send_event(make_event(3, 65535, 65535, 0, 65535, 65535, 65535, 65535));
  endtask

  // random traffic in phases, each with its own setting and idling profile
  task automatic test_random_traffic(input int phases, input int per_phase);
    int burst_left;
    int max_gap;
    for (int p = 0; p < phases; p++) begin
      // walk every mode with the bench on, disabled now and then, both
      // extremes first; later phases pick settings at random
      if (p < 10) begin
        write_reg(REG_BENCH_ENABLE, {1'($urandom_range(1)), 1'(p % 5 != 4)});
        write_reg(REG_CHANNEL_MODE, mode_t'(p % 4));
      end else begin
        write_reg(REG_BENCH_ENABLE, CFG_DATA_W'($urandom_range(3)));
        write_reg(REG_CHANNEL_MODE, CFG_DATA_W'($urandom_range(3)));
      end
      // first phase runs flat out on both sides
      if (p == 0) begin
        stall_pct = 0;
        max_gap   = 0;
      end else begin
        stall_pct = $urandom_range(40);
        max_gap   = $urandom_range(30, 2);
      end
      burst_left = $urandom_range(12, 1);
      for (int n = 0; n < per_phase; n++) begin
        send_event(random_event());
        // hold back once until every result is in
        if (p == 5 && n == per_phase / 2) wait_drained();
        burst_left--;
        if (burst_left == 0) begin
          idle_sender($urandom_range(max_gap));
          burst_left = $urandom_range(12, 1);
        end
      end
      stall_pct = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_disabled_after_reset();
    test_feed_modes();
    test_random_traffic(10, 105);
    wait_drained();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
